### hdl/mkic_pkg.sv
// Shared types and constants for the multi-kernel image convolver.
`timescale 1ns / 1ps
package mkic_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int POS_W          = 14;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int ACC_W          = 25;
  localparam int MIN_SIZE       = 5;

  typedef logic [7:0] pix_t;
  typedef pix_t [4:0] col_t;
  typedef col_t [4:0] win_t;

  typedef enum logic [2:0] {
    MODE_CROSS = 3'd0,
    MODE_DIAG  = 3'd1,
    MODE_LAPL  = 3'd2,
    MODE_SHARP = 3'd3,
    MODE_EMBOS = 3'd4,
    MODE_GAUSS = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } meta_t;

  localparam logic [ACC_W-1:0] G_CORNER = 25'd49;
  localparam logic [ACC_W-1:0] G_EDGE1  = 25'd513;
  localparam logic [ACC_W-1:0] G_EDGE2  = 25'd1121;
  localparam logic [ACC_W-1:0] G_INDIAG = 25'd5347;
  localparam logic [ACC_W-1:0] G_INCROS = 25'd11679;
  localparam logic [ACC_W-1:0] G_CENTER = 25'd25509;
  localparam logic [ACC_W-1:0] G_ROUND  = 25'd51200;
  localparam logic [25:0]      RECIP25  = 26'd5243;
  localparam logic [22:0]      RECIP5   = 23'd3277;
endpackage

### hdl/mkic_col_cell.sv
// One window column cell: holds five pixels and passes them to its neighbor.
`timescale 1ns / 1ps
module mkic_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  mkic_pkg::col_t col_in,
  output mkic_pkg::col_t col_out
);
  mkic_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (load) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
endmodule

### hdl/mkic_kernel.sv
// Kernel arithmetic: three stages from the window to the output register.
`timescale 1ns / 1ps
module mkic_kernel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [2:0]            mode,
  input  mkic_pkg::win_t        win,
  input  logic                  emit_in,
  input  mkic_pkg::meta_t       meta_in,
  output logic                  out_valid,
  output logic [7:0]            out_value,
  output mkic_pkg::meta_t       out_meta
);
  logic                  vc_r, vd_r, ve_r;
  mkic_pkg::meta_t       mc_r, md_r, me_r;
  logic signed [12:0]    sc_r, sc_nxt;
  logic [10:0]           g0_r, g1_r, g2_r, g3_r, g4_r;
  logic [7:0]            g5_r;
  logic [mkic_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [7:0]            vd_val_r, vd_nxt, ve_val_r, ve_nxt;
  logic [10:0]           n8;
  logic [22:0]           p5;
  logic [mkic_pkg::ACC_W-1:0] rsum;
  logic [25:0]           p25;
  logic [8:0]            q25;

  function automatic logic [10:0] px(input mkic_pkg::win_t w, input int r, input int c);
    px = 11'(w[c][r]);
  endfunction

  assign n8 = px(win,2,2) + px(win,2,3) + px(win,2,4) + px(win,3,2) + px(win,3,4)
            + px(win,4,2) + px(win,4,3) + px(win,4,4);

  always_comb begin
    sc_nxt = '0;
    case (mode)
      mkic_pkg::MODE_CROSS: sc_nxt = 13'(px(win,2,3) + px(win,4,3) + px(win,3,2)
                                       + px(win,3,4) + px(win,3,3) + 11'd2);
      mkic_pkg::MODE_DIAG:  sc_nxt = 13'(px(win,0,0) + px(win,1,1) + px(win,2,2)
                                       + px(win,3,3) + px(win,4,4));
      mkic_pkg::MODE_LAPL:  sc_nxt = $signed({2'b0, px(win,3,3)} << 3) - $signed({2'b0, n8});
      mkic_pkg::MODE_SHARP: sc_nxt = $signed(({2'b0, px(win,3,3)} << 3) + {2'b0, px(win,3,3)})
                                   - $signed({2'b0, n8});
      mkic_pkg::MODE_EMBOS: sc_nxt = $signed({2'b0, px(win,3,4) + px(win,4,3) + px(win,4,4)})
                                   - $signed({2'b0, px(win,2,2) + px(win,2,3) + px(win,3,2)});
      default:              sc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      vc_r <= emit_in;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r <= meta_in;
      sc_r <= sc_nxt;
      g0_r <= px(win,0,0) + px(win,0,4) + px(win,4,0) + px(win,4,4);
      g1_r <= px(win,0,1) + px(win,0,3) + px(win,1,0) + px(win,3,0)
            + px(win,1,4) + px(win,3,4) + px(win,4,1) + px(win,4,3);
      g2_r <= px(win,0,2) + px(win,2,0) + px(win,2,4) + px(win,4,2);
      g3_r <= px(win,1,1) + px(win,1,3) + px(win,3,1) + px(win,3,3);
      g4_r <= px(win,1,2) + px(win,2,1) + px(win,2,3) + px(win,3,2);
      g5_r <= win[2][2];
      md_r <= mc_r;
      acc_r <= acc_nxt;
      vd_val_r <= vd_nxt;
      me_r <= md_r;
      ve_val_r <= ve_nxt;
    end
  end

  assign p5 = 23'(sc_r[10:0]) * mkic_pkg::RECIP5;
  assign acc_nxt = mkic_pkg::G_CORNER * 25'(g0_r) + mkic_pkg::G_EDGE1 * 25'(g1_r)
                 + mkic_pkg::G_EDGE2 * 25'(g2_r) + mkic_pkg::G_INDIAG * 25'(g3_r)
                 + mkic_pkg::G_INCROS * 25'(g4_r) + mkic_pkg::G_CENTER * 25'(g5_r);

  always_comb begin
    vd_nxt = '0;
    case (mode)
      mkic_pkg::MODE_CROSS, mkic_pkg::MODE_DIAG: vd_nxt = p5[21:14];
      mkic_pkg::MODE_LAPL, mkic_pkg::MODE_SHARP, mkic_pkg::MODE_EMBOS: begin
        if (sc_r < 0) vd_nxt = 8'd0;
        else if (sc_r > 13'sd255) vd_nxt = 8'd255;
        else vd_nxt = sc_r[7:0];
      end
      default: vd_nxt = '0;
    endcase
  end

  assign rsum = acc_r + mkic_pkg::G_ROUND;
  assign p25  = 26'(rsum[24:12]) * mkic_pkg::RECIP25;
  assign q25  = p25[25:17];

  always_comb begin
    if (mode == mkic_pkg::MODE_GAUSS) begin
      ve_nxt = q25[8] ? 8'd255 : q25[7:0];
    end else begin
      ve_nxt = vd_val_r;
    end
  end

  assign out_valid = ve_r;
  assign out_value = ve_val_r;
  assign out_meta  = me_r;
endmodule

### hdl/multi_kernel_image_convolver_unit.sv
// Top level: position counters, line store, window cell chain and kernel pipeline.
// Pipeline: a pixel passes the input registers, the window cells and the kernel stages before its result is shown.
// Throughput: one pixel per cycle; the whole pipeline holds while out_stall holds a result.
// Line store: four lines, one read and one write port each, read data registered.
// Reset: rst_n synchronous; counters and window cleared, mode 0, size 1024 x 1024.
`timescale 1ns / 1ps
module multi_kernel_image_convolver_unit #(
  parameter int MAX_WIDTH  = mkic_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mkic_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_value,
  output logic [9:0]                        out_column,
  output logic [9:0]                        out_row,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mkic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkic_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = mkic_pkg::POS_W;

  logic [2:0]                      mode_r;
  logic [mkic_pkg::CFG_DATA_W-1:0] fw_r, fh_r;
  logic [CW-1:0]                   c_r, c_nxt, a_addr_r;
  logic [RW-1:0]                   r_r, r_nxt;
  logic [PW-1:0]                   w_eff, h_eff, cx, rx, lat, lat2;
  logic                            en, acc, emit, va_r, ea_r, eb_r;
  mkic_pkg::meta_t                 meta, ma_r, mb_r, k_meta;
  mkic_pkg::pix_t                  pa_r;
  mkic_pkg::pix_t                  mem0 [MAX_WIDTH];
  mkic_pkg::pix_t                  mem1 [MAX_WIDTH];
  mkic_pkg::pix_t                  mem2 [MAX_WIDTH];
  mkic_pkg::pix_t                  mem3 [MAX_WIDTH];
  mkic_pkg::pix_t                  rd0_r, rd1_r, rd2_r, rd3_r;
  mkic_pkg::col_t                  new_col;
  mkic_pkg::win_t                  win;
  logic                            k_valid;
  logic [7:0]                      k_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mkic_pkg::MODE_CROSS;
      fw_r   <= mkic_pkg::CFG_DATA_W'(1024);
      fh_r   <= mkic_pkg::CFG_DATA_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mkic_pkg::REG_MODE:   mode_r <= cfg_data[2:0];
        mkic_pkg::REG_WIDTH:  fw_r   <= cfg_data;
        mkic_pkg::REG_HEIGHT: fh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (PW'(fw_r) < PW'(mkic_pkg::MIN_SIZE)) w_eff = PW'(mkic_pkg::MIN_SIZE);
    else if (PW'(fw_r) > PW'(MAX_WIDTH)) w_eff = PW'(MAX_WIDTH);
    else w_eff = PW'(fw_r);
    if (PW'(fh_r) < PW'(mkic_pkg::MIN_SIZE)) h_eff = PW'(mkic_pkg::MIN_SIZE);
    else if (PW'(fh_r) > PW'(MAX_HEIGHT)) h_eff = PW'(MAX_HEIGHT);
    else h_eff = PW'(fh_r);
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign cx   = PW'(c_r);
  assign rx   = PW'(r_r);
  assign lat  = (mode_r == mkic_pkg::MODE_DIAG || mode_r == mkic_pkg::MODE_GAUSS)
              ? PW'(2) : PW'(1);
  assign lat2 = lat << 1;
  assign emit = (rx >= lat2) && (cx >= lat2) && (rx <= h_eff - PW'(1))
             && (cx <= w_eff - PW'(1));
  assign meta.col  = 10'(cx - lat);
  assign meta.row  = 10'(rx - lat);
  assign meta.last = (rx == h_eff - PW'(1)) && (cx == w_eff - PW'(1));

  always_comb begin
    c_nxt = c_r;
    r_nxt = r_r;
    if (cx >= w_eff - PW'(1)) begin
      c_nxt = '0;
      r_nxt = (rx >= h_eff - PW'(1)) ? '0 : r_r + RW'(1);
    end else begin
      c_nxt = c_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r  <= '0;
      r_r  <= '0;
      va_r <= 1'b0;
      ea_r <= 1'b0;
      eb_r <= 1'b0;
    end else if (en) begin
      va_r <= acc;
      ea_r <= acc && emit;
      eb_r <= ea_r;
      if (acc) begin
        c_r <= c_nxt;
        r_r <= r_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= in_pixel;
      a_addr_r <= c_r;
      ma_r     <= meta;
      mb_r     <= ma_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) rd0_r <= mem0[c_r];
    if (en && va_r) mem0[a_addr_r] <= rd1_r;
  end
  always_ff @(posedge clk) begin
    if (en) rd1_r <= mem1[c_r];
    if (en && va_r) mem1[a_addr_r] <= rd2_r;
  end
  always_ff @(posedge clk) begin
    if (en) rd2_r <= mem2[c_r];
    if (en && va_r) mem2[a_addr_r] <= rd3_r;
  end
  always_ff @(posedge clk) begin
    if (en) rd3_r <= mem3[c_r];
    if (en && va_r) mem3[a_addr_r] <= pa_r;
  end

  assign new_col = {pa_r, rd3_r, rd2_r, rd1_r, rd0_r};

  for (genvar j = 0; j < 5; j++) begin : g_cell
    mkic_col_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (en && va_r),
      .col_in  ((j == 4) ? new_col : win[(j == 4) ? 4 : j + 1]),
      .col_out (win[j])
    );
  end

  mkic_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mode      (mode_r),
    .win       (win),
    .emit_in   (eb_r),
    .meta_in   (mb_r),
    .out_valid (k_valid),
    .out_value (k_value),
    .out_meta  (k_meta)
  );

  assign out_valid  = k_valid;
  assign out_value  = k_value;
  assign out_column = k_meta.col;
  assign out_row    = k_meta.row;
  assign out_last   = k_meta.last;
endmodule

### hdl/mkic_checker.sv
// Port-level checks for the convolver, bound to the top level.
`timescale 1ns / 1ps
module mkic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_value,
  input logic [9:0] out_column,
  input logic       cfg_valid,
  input logic       cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_column))
    else $error("stalled beat changed");

  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output beat");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat shown after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_valid |-> cfg_ready)
    else $error("config write refused");
endmodule

bind multi_kernel_image_convolver_unit mkic_checker u_mkic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_value  (out_value),
  .out_column (out_column),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
